// ===== design/ata_rd_pkg.sv =====
package ata_rd_pkg;

  // input opcodes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  // sector geometry and error masking
  localparam int         WORDS_PER_SECTOR = 256;
  localparam logic [7:0] LAST_WORD        = 8'(WORDS_PER_SECTOR - 1);
  localparam logic [2:0] IGNORE_POLLS     = 3'd4;
  localparam logic [16:0] BYTES_PER_WORD  = 17'd2;

  // register offsets from the channel base
  localparam logic [15:0] OFF_DATA  = 16'h0000;
  localparam logic [15:0] OFF_FEAT  = 16'h0001;
  localparam logic [15:0] OFF_SECN  = 16'h0002;
  localparam logic [15:0] OFF_LBA0  = 16'h0003;
  localparam logic [15:0] OFF_LBA1  = 16'h0004;
  localparam logic [15:0] OFF_LBA2  = 16'h0005;
  localparam logic [15:0] OFF_DRVH  = 16'h0006;
  localparam logic [15:0] OFF_CMD   = 16'h0007;
  localparam logic [15:0] OFF_CTRL  = 16'h0206;

  // status bits
  localparam logic [7:0] ST_BSY = 8'h80;
  localparam logic [7:0] ST_RDY = 8'h40;
  localparam logic [7:0] ST_DF  = 8'h20;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_ERR = 8'h01;

  localparam logic [7:0] CTRL_SRST     = 8'h04;
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] DRV_HEAD_BASE = 8'hE0;

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_DISCARD = 3'd1,
    ACT_STATUS  = 3'd2,
    ACT_DATA    = 3'd3,
    ACT_HOST    = 3'd4,
    ACT_FINISH  = 3'd5
  } action_t;

  // result run kinds produced by one input item
  typedef enum logic [2:0] {
    K_FIN,        // finish
    K_STAT,       // one status poll
    K_SRST,       // soft reset sequence
    K_CMD,        // task file writes, read command, status poll
    K_DREAD,      // one data read
    K_WORD_DREAD, // host word, next data read
    K_WORD_POLL,  // host word, delay reads, status poll
    K_WORD_FIN    // host word, delay reads, finish
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [27:0] lba;
    logic [7:0]  count;
    logic        drive;
    logic [15:0] word;
    logic [16:0] bytes;
    logic        fail;
  } desc_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] port;
    logic [7:0]  wbyte;
    logic [15:0] hword;
    logic [16:0] bcount;
    logic        failed;
    logic        last;
  } result_t;

  function automatic logic [2:0] last_idx(input kind_t k);
    logic [2:0] n;
    case (k)
      K_SRST:       n = 3'd6;
      K_CMD:        n = 3'd7;
      K_WORD_DREAD: n = 3'd1;
      K_WORD_POLL:  n = 3'd5;
      K_WORD_FIN:   n = 3'd5;
      default:      n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic result_t result_at(input desc_t d, input logic [2:0] idx,
                                        input logic [15:0] base);
    result_t     r;
    logic [15:0] off;
    r        = '0;
    off      = OFF_CTRL;
    r.bcount = d.bytes;
    r.last   = (idx == last_idx(d.kind));
    case (d.kind)
      K_FIN: begin
        r.action = ACT_FINISH;
        r.failed = d.fail;
      end
      K_STAT: r.action = ACT_STATUS;
      K_SRST: begin
        case (idx)
          3'd0: begin
            r.action = ACT_WRITE;
            r.wbyte  = CTRL_SRST;
          end
          3'd1:    r.action = ACT_WRITE;
          3'd6:    r.action = ACT_STATUS;
          default: r.action = ACT_DISCARD;
        endcase
      end
      K_CMD: begin
        r.action = ACT_WRITE;
        case (idx)
          3'd0: begin
            off     = OFF_DRVH;
            r.wbyte = DRV_HEAD_BASE | {3'b000, d.drive, d.lba[27:24]};
          end
          3'd1: off = OFF_FEAT;
          3'd2: begin
            off     = OFF_SECN;
            r.wbyte = d.count;
          end
          3'd3: begin
            off     = OFF_LBA0;
            r.wbyte = d.lba[7:0];
          end
          3'd4: begin
            off     = OFF_LBA1;
            r.wbyte = d.lba[15:8];
          end
          3'd5: begin
            off     = OFF_LBA2;
            r.wbyte = d.lba[23:16];
          end
          3'd6: begin
            off     = OFF_CMD;
            r.wbyte = CMD_READ;
          end
          default: r.action = ACT_STATUS;
        endcase
      end
      K_DREAD: begin
        r.action = ACT_DATA;
        off      = OFF_DATA;
      end
      K_WORD_DREAD: begin
        if (idx == 3'd0) begin
          r.action = ACT_HOST;
          r.hword  = d.word;
        end else begin
          r.action = ACT_DATA;
          off      = OFF_DATA;
        end
      end
      K_WORD_POLL, K_WORD_FIN: begin
        if (idx == 3'd0) begin
          r.action = ACT_HOST;
          r.hword  = d.word;
        end else if (idx == 3'd5) begin
          if (d.kind == K_WORD_POLL) begin
            r.action = ACT_STATUS;
          end else begin
            r.action = ACT_FINISH;
            r.failed = d.fail;
          end
        end else begin
          r.action = ACT_DISCARD;
        end
      end
      default: r.action = ACT_FINISH;
    endcase
    if (r.action inside {ACT_WRITE, ACT_DISCARD, ACT_STATUS, ACT_DATA}) begin
      r.port = base + off;
    end
    return r;
  endfunction

endpackage

// ===== design/ata_pio_lba28_read_sequencer.sv =====
// ATA PIO LBA28 read sequencer, host side.
// s_* channel takes items: tuser is the opcode (start, status byte, data word),
// tdata carries the start parameters and the bus answers. m_* channel gives
// results: tuser is the bus or host action, tlast marks the last result of
// one input item, tdata carries port, written byte, host word, count, failed.
// cfg_wen/cfg_wdata write the channel I/O base; write it only while idle.
// An accepted item is decoded in the cycle it is accepted: the sequencer
// state moves on and a run descriptor is registered. Results are built from
// it and registered in the output register, one per cycle unless stalled.
// A run is 0 to 8 results (8 for the command issue); the next item is taken
// in the same cycle the last result of the run is loaded into the output
// register. Items that cause no result are taken every cycle.
// Reset (rst, synchronous) returns the sequencer to idle, drops any run and
// any pending result, and sets the base to 0x1F0.
// When the receiver stalls, the output register holds its result and the
// run stops where it is; input is refused until the run's last result loads.
module ata_pio_lba28_read_sequencer
  import ata_rd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [27:0] lba, [35:28] sector_count, [36] drive, [53:37] capacity_bytes,
  // [61:54] status_byte, [77:62] data_word, [79:78] zero
  input  logic [79:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] port, [23:16] write_byte, [39:24] host_word, [56:40] byte_count,
  // [57] failed, [63:58] zero
  output logic [63:0] m_tdata,
  // [2:0] action
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CHECK,
    PH_RESET,
    PH_POLL,
    PH_DATA
  } phase_t;

  // input field view
  logic [27:0] in_lba;
  logic [7:0]  in_count;
  logic        in_drive;
  logic [16:0] in_cap;
  logic [7:0]  in_status;
  logic [15:0] in_word;

  assign in_lba    = s_tdata[27:0];
  assign in_count  = s_tdata[35:28];
  assign in_drive  = s_tdata[36];
  assign in_cap    = s_tdata[53:37];
  assign in_status = s_tdata[61:54];
  assign in_word   = s_tdata[77:62];

  // sequencer state
  logic [15:0] base_port;
  phase_t      phase, phase_next;
  logic [27:0] start_lba, start_lba_next;
  logic [7:0]  sectors_left, sectors_left_next;
  logic        drive_sel, drive_sel_next;
  logic [2:0]  poll_index, poll_index_next;
  logic        ignore_errors, ignore_errors_next;
  logic [7:0]  word_index, word_index_next;
  logic [16:0] bytes_done, bytes_done_next;

  // run descriptor and emitter
  desc_t       desc, desc_next;
  logic        has_res;
  logic        busy;
  logic [2:0]  idx;
  result_t     cur_res;
  result_t     out_res;
  logic        load;
  logic        accept;

  assign cur_res  = result_at(desc, idx, base_port);
  assign load     = busy && (!m_tvalid || m_tready);
  // free when no run is open, or when its last result loads this cycle
  assign s_tready = !busy || (load && cur_res.last);
  assign accept   = s_tvalid && s_tready;

  // decode of one item against the current phase
  always_comb begin
    logic ign_eff;
    logic poll_done;
    logic issue;
    logic bad;
    phase_next         = phase;
    start_lba_next     = start_lba;
    sectors_left_next  = sectors_left;
    drive_sel_next     = drive_sel;
    poll_index_next    = poll_index;
    ignore_errors_next = ignore_errors;
    word_index_next    = word_index;
    bytes_done_next    = bytes_done;
    desc_next          = desc;
    desc_next.fail     = 1'b0;
    desc_next.word     = in_word;
    has_res            = 1'b0;
    issue              = 1'b0;
    bad                = ((in_status & (ST_ERR | ST_DF)) != 8'h00);
    // errors stay masked until the early polls have gone by
    ign_eff   = ignore_errors && (poll_index < IGNORE_POLLS);
    poll_done = ((in_status & ST_BSY) == 8'h00) &&
                (((in_status & ST_DRQ) != 8'h00) || (!ign_eff && bad));
    case (s_tuser)
      OP_START: begin
        start_lba_next     = in_lba;
        sectors_left_next  = in_count;
        drive_sel_next     = in_drive;
        bytes_done_next    = '0;
        word_index_next    = '0;
        poll_index_next    = '0;
        ignore_errors_next = 1'b1;
        has_res            = 1'b1;
        // zero count or buffer shorter than count sectors
        if (in_count == 8'd0 || in_cap < {in_count, 9'b0}) begin
          desc_next.kind = K_FIN;
          desc_next.fail = 1'b1;
          phase_next     = PH_IDLE;
        end else begin
          desc_next.kind = K_STAT;
          phase_next     = PH_CHECK;
        end
      end
      OP_STATUS: begin
        case (phase)
          PH_CHECK: begin
            has_res = 1'b1;
            if ((in_status & (ST_BSY | ST_DRQ)) != 8'h00) begin
              desc_next.kind = K_SRST;
              phase_next     = PH_RESET;
            end else begin
              issue = 1'b1;
            end
          end
          PH_RESET: begin
            has_res = 1'b1;
            if ((in_status & ST_BSY) == 8'h00 && (in_status & ST_RDY) != 8'h00) begin
              issue = 1'b1;
            end else begin
              desc_next.kind = K_STAT;
            end
          end
          PH_POLL: begin
            has_res            = 1'b1;
            ignore_errors_next = ign_eff;
            if (!poll_done) begin
              if (poll_index < IGNORE_POLLS) begin
                poll_index_next = poll_index + 3'd1;
              end
              desc_next.kind = K_STAT;
            end else if (bad) begin
              desc_next.kind = K_FIN;
              desc_next.fail = 1'b1;
              phase_next     = PH_IDLE;
            end else begin
              ignore_errors_next = 1'b0;
              sectors_left_next  = sectors_left - 8'd1;
              word_index_next    = '0;
              desc_next.kind     = K_DREAD;
              phase_next         = PH_DATA;
            end
          end
          default: ;
        endcase
      end
      OP_DATA: begin
        if (phase == PH_DATA) begin
          has_res         = 1'b1;
          bytes_done_next = bytes_done + BYTES_PER_WORD;
          if (word_index != LAST_WORD) begin
            word_index_next = word_index + 8'd1;
            desc_next.kind  = K_WORD_DREAD;
          end else begin
            word_index_next = '0;
            if (sectors_left != 8'd0) begin
              poll_index_next = '0;
              desc_next.kind  = K_WORD_POLL;
              phase_next      = PH_POLL;
            end else begin
              desc_next.kind = K_WORD_FIN;
              phase_next     = PH_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
    if (issue) begin
      desc_next.kind     = K_CMD;
      poll_index_next    = '0;
      ignore_errors_next = 1'b1;
      phase_next         = PH_POLL;
    end
    desc_next.lba   = start_lba_next;
    desc_next.count = sectors_left_next;
    desc_next.drive = drive_sel_next;
    desc_next.bytes = bytes_done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_port     <= 16'h01F0;
      phase         <= PH_IDLE;
      start_lba     <= '0;
      sectors_left  <= '0;
      drive_sel     <= 1'b0;
      poll_index    <= '0;
      ignore_errors <= 1'b1;
      word_index    <= '0;
      bytes_done    <= '0;
      busy          <= 1'b0;
      idx           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        base_port <= cfg_wdata;
      end
      // output register
      if (load) begin
        m_tvalid <= 1'b1;
        out_res  <= cur_res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // run bookkeeping; a new run overrides the one just ending
      if (accept) begin
        phase         <= phase_next;
        start_lba     <= start_lba_next;
        sectors_left  <= sectors_left_next;
        drive_sel     <= drive_sel_next;
        poll_index    <= poll_index_next;
        ignore_errors <= ignore_errors_next;
        word_index    <= word_index_next;
        bytes_done    <= bytes_done_next;
        desc          <= desc_next;
        busy          <= has_res;
        idx           <= '0;
      end else if (load) begin
        if (cur_res.last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  assign m_tdata = {6'b000000, out_res.failed, out_res.bcount, out_res.hword,
                    out_res.wbyte, out_res.port};
  assign m_tuser = out_res.action;
  assign m_tlast = out_res.last;

endmodule
